@@ hw/rtl/klx_pkg.sv @@
package klx_pkg;

    localparam int MAX_LEXEME = 63;
    localparam int LEN_W      = 6;
    localparam int LINE_W     = 16;
    localparam int NUM_KW     = 5;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        KIND_KEYWORD = 4'd0,
        KIND_IDENT   = 4'd1,
        KIND_NUMBER  = 4'd2,
        KIND_ASSIGN  = 4'd3,
        KIND_PLUS    = 4'd4,
        KIND_SEMI    = 4'd5,
        KIND_LPAREN  = 4'd6,
        KIND_RPAREN  = 4'd7,
        KIND_UNKNOWN = 4'd8,
        KIND_EOF     = 4'd9
    } kind_t;

    // Keyword spellings, padded with zeros to eight positions
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h61, 8'h6E, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h62, 8'h6F, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h67, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6A, 8'h61, 8'h62, 8'h74, 8'h61, 8'h6B, 8'h00, 8'h00},
        '{8'h6E, 8'h61, 8'h69, 8'h74, 8'h6F, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        LEN_W'(3), LEN_W'(3), LEN_W'(4), LEN_W'(6), LEN_W'(5)
    };

    typedef struct packed {
        kind_t            kind;
        logic [2:0]       kwi;
        logic [LEN_W-1:0] len;
        logic             too_long;
        logic [7:0]       first;
    } tok_t;

    typedef struct packed {
        tok_t              tok0;
        tok_t              tok1;
        logic              two;
        logic [LINE_W-1:0] line;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [NUM_KW-1:0] mask_step(input logic [NUM_KW-1:0] mask,
                                                    input logic [LEN_W-1:0] pos,
                                                    input logic [7:0] c);
        logic [NUM_KW-1:0] r;
        r = '0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            r[k] = mask[k] && (pos < KW_LEN[k]) && (KW_TEXT[k][pos[2:0]] == c);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/keyword_aware_lexer.sv @@
// Channel | Handshake                 | Payload
// --------+---------------------------+---------------------------------------------
// byte    | byte_valid / byte_stall   | in_byte, end_mark
// token   | token_valid / token_stall | token_kind, keyword_index, token_length,
//         |                           | too_long, token_line, first_char, last_of_run
//
// One byte is taken every cycle while the four-entry token queue has room.
// Tokens leave at one per cycle from a registered output while token_stall is low;
// a byte giving a flushed token plus its own token sends the flushed one first.
// A token passes from its byte's transfer through the queue to the registered output.
// rst_n clears the scanner, the queue and the output valid asynchronously.
// byte_stall is the queue full flag; token_stall only holds the output stage.
module keyword_aware_lexer
    import klx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [7:0]        in_byte,
    input  logic              end_mark,
    output logic              token_valid,
    input  logic              token_stall,
    output logic [3:0]        token_kind,
    output logic [2:0]        keyword_index,
    output logic [LEN_W-1:0]  token_length,
    output logic              too_long,
    output logic [LINE_W-1:0] token_line,
    output logic [7:0]        first_char,
    output logic              last_of_run
);

    q_status_t q_status;
    entry_t    push_data, pop_data;
    logic      push, pop, accept;
    tok_t      out_tok;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !q_status.full;

    klx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .end_mark  (end_mark),
        .push      (push),
        .push_data (push_data)
    );

    klx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    klx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (token_valid),
        .out_stall (token_stall),
        .out_tok   (out_tok),
        .out_line  (token_line),
        .out_last  (last_of_run)
    );

    assign token_kind    = 4'(out_tok.kind);
    assign keyword_index = out_tok.kwi;
    assign token_length  = out_tok.len;
    assign too_long      = out_tok.too_long;
    assign first_char    = out_tok.first;

endmodule

@@ hw/rtl/klx_queue.sv @@
module klx_queue
    import klx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_data,
    input  logic      pop,
    output entry_t    pop_data,
    output q_status_t status
);

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/klx_front.sv @@
module klx_front
    import klx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_mark,
    output logic       push,
    output entry_t     push_data
);

    mode_t              mode_reg, mode_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [NUM_KW-1:0]  mask_reg, mask_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [7:0]         first_reg, first_next;
    logic               ovf_reg, ovf_next;

    logic is_letter, is_digit, is_space, is_punct;
    logic cont_word, cont_num, cont;
    logic flush_valid, single_valid;
    tok_t flush_tok, single_tok;

    assign is_letter = (in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                       (in_byte >= 8'h41 && in_byte <= 8'h5A);
    assign is_digit  = (in_byte >= 8'h30 && in_byte <= 8'h39);
    assign is_space  = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    assign is_punct  = !is_letter && !is_digit && !is_space;

    assign cont_word = (mode_reg == MODE_WORD) && (is_letter || is_digit);
    assign cont_num  = (mode_reg == MODE_NUM) && is_digit;
    assign cont      = !end_mark && (cont_word || cont_num);

    assign flush_valid  = (mode_reg != MODE_IDLE) && !cont;
    assign single_valid = end_mark || (!cont && is_punct);

    // token output side
    always_comb
    begin
        flush_tok.kind     = (mode_reg == MODE_WORD) ? KIND_IDENT : KIND_NUMBER;
        flush_tok.kwi      = '0;
        flush_tok.len      = count_reg;
        flush_tok.too_long = ovf_reg;
        flush_tok.first    = first_reg;
        if (mode_reg == MODE_WORD && !ovf_reg)
        begin
            // lowest matching keyword wins
            for (int k = NUM_KW - 1; k >= 0; k--)
            begin
                if (mask_reg[k] && KW_LEN[k] == count_reg)
                begin
                    flush_tok.kind = KIND_KEYWORD;
                    flush_tok.kwi  = 3'(k);
                end
            end
        end

        single_tok.kwi      = '0;
        single_tok.too_long = 1'b0;
        single_tok.len      = LEN_W'(1);
        single_tok.first    = in_byte;
        unique case (in_byte)
            CH_ASSIGN: single_tok.kind = KIND_ASSIGN;
            CH_PLUS:   single_tok.kind = KIND_PLUS;
            CH_SEMI:   single_tok.kind = KIND_SEMI;
            CH_LPAREN: single_tok.kind = KIND_LPAREN;
            CH_RPAREN: single_tok.kind = KIND_RPAREN;
            default:   single_tok.kind = KIND_UNKNOWN;
        endcase
        if (end_mark)
        begin
            single_tok.kind  = KIND_EOF;
            single_tok.len   = '0;
            single_tok.first = '0;
        end

        push_data.line = line_reg;
        if (flush_valid)
        begin
            push_data.tok0 = flush_tok;
            push_data.tok1 = single_tok;
            push_data.two  = single_valid;
        end
        else
        begin
            push_data.tok0 = single_tok;
            push_data.tok1 = single_tok;
            push_data.two  = 1'b0;
        end
        push = accept && (flush_valid || single_valid);
    end

    // scanner state
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        mask_next  = mask_reg;
        line_next  = line_reg;
        first_next = first_reg;
        ovf_next   = ovf_reg;
        if (end_mark)
        begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            mask_next  = '1;
            line_next  = LINE_W'(1);
            first_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cont)
        begin
            if (cont_word)
            begin
                mask_next = mask_step(mask_reg, count_reg, in_byte);
            end
            if (count_reg < LEN_W'(MAX_LEXEME))
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else
        begin
            mode_next = MODE_IDLE;
            if (is_letter || is_digit)
            begin
                mode_next  = is_letter ? MODE_WORD : MODE_NUM;
                count_next = LEN_W'(1);
                first_next = in_byte;
                ovf_next   = 1'b0;
                mask_next  = is_letter ? mask_step('1, '0, in_byte) : '1;
            end
            else if (in_byte == CH_NL && line_reg != '1)
            begin
                line_next = line_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            mask_reg  <= '1;
            line_reg  <= LINE_W'(1);
            first_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            mask_reg  <= mask_next;
            line_reg  <= line_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ hw/rtl/klx_back.sv @@
module klx_back
    import klx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  q_status_t         q_status,
    input  entry_t            q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output tok_t              out_tok,
    output logic [LINE_W-1:0] out_line,
    output logic              out_last
);

    logic              out_valid_reg, out_valid_next;
    tok_t              out_tok_reg, out_tok_next;
    logic [LINE_W-1:0] out_line_reg, out_line_next;
    logic              out_last_reg, out_last_next;
    logic              hold_valid_reg, hold_valid_next;
    tok_t              hold_tok_reg, hold_tok_next;
    logic [LINE_W-1:0] hold_line_reg, hold_line_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_tok_next    = out_tok_reg;
        out_line_next   = out_line_reg;
        out_last_next   = out_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_tok_next   = hold_tok_reg;
        hold_line_next  = hold_line_reg;
        q_pop           = 1'b0;
        if (slot_free)
        begin
            // second token of an entry goes out before the next entry
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_tok_next    = hold_tok_reg;
                out_line_next   = hold_line_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (!q_status.empty)
            begin
                q_pop           = 1'b1;
                out_valid_next  = 1'b1;
                out_tok_next    = q_data.tok0;
                out_line_next   = q_data.line;
                out_last_next   = !q_data.two;
                hold_valid_next = q_data.two;
                hold_tok_next   = q_data.tok1;
                hold_line_next  = q_data.line;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg   <= out_tok_next;
        out_line_reg  <= out_line_next;
        out_last_reg  <= out_last_next;
        hold_tok_reg  <= hold_tok_next;
        hold_line_reg <= hold_line_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;
    assign out_line  = out_line_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hw/rtl/klx_checker.sv @@
module klx_checker
    import klx_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              token_valid,
    input logic              token_stall,
    input logic [3:0]        token_kind,
    input logic [2:0]        keyword_index,
    input logic [LEN_W-1:0]  token_length,
    input logic              too_long,
    input logic [LINE_W-1:0] token_line,
    input logic [7:0]        first_char,
    input logic              last_of_run
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid)
        else $error("token valid dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> $stable(token_kind) && $stable(token_line)
            && $stable(first_char) && $stable(token_length) && $stable(last_of_run))
        else $error("stalled token changed");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == 4'(KIND_EOF) |->
            last_of_run && token_length == '0 && first_char == '0)
        else $error("eof token malformed");

    a_kwi_only_keyword: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != 4'(KIND_KEYWORD) |-> keyword_index == '0)
        else $error("keyword index on non-keyword token");

    a_too_long_sat: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && too_long |->
            token_length == LEN_W'(MAX_LEXEME) && token_kind != 4'(KIND_KEYWORD))
        else $error("overlong token inconsistent");

endmodule

bind keyword_aware_lexer klx_checker u_klx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .token_kind    (token_kind),
    .keyword_index (keyword_index),
    .token_length  (token_length),
    .too_long      (too_long),
    .token_line    (token_line),
    .first_char    (first_char),
    .last_of_run   (last_of_run)
);
